>>> rtl/core/c8core_pkg.sv
// ----------------------------------------------------------------------------
// c8core_pkg
// shared constants and types of the chip-8 instruction core
// ----------------------------------------------------------------------------
package c8core_pkg;

    localparam int MEMORY_BYTES_DEF  = 4096;
    localparam int STACK_DEPTH_DEF   = 16;
    localparam int SCREEN_WIDTH_DEF  = 64;
    localparam int SCREEN_HEIGHT_DEF = 32;

    localparam int ADDR_W = 12;
    localparam int ROW_W  = 5;
    localparam int COL_W  = 6;

    localparam logic [ADDR_W-1:0] PROG_BASE = 12'h200;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_EXEC  = 2'd1;
    localparam logic [1:0] KIND_PIXEL = 2'd2;
    localparam logic [1:0] KIND_REG   = 2'd3;

    localparam logic [15:0] OP_CLS = 16'h00E0;
    localparam logic [15:0] OP_RET = 16'h00EE;
    localparam logic [7:0]  NN_LD_DT = 8'h07;
    localparam logic [7:0]  NN_ST_DT = 8'h15;
    localparam logic [7:0]  NN_ST_ST = 8'h18;

    // opcode groups (top nibble)
    localparam logic [3:0] GRP_JP   = 4'h1;
    localparam logic [3:0] GRP_CALL = 4'h2;
    localparam logic [3:0] GRP_SE   = 4'h3;
    localparam logic [3:0] GRP_SNE  = 4'h4;
    localparam logic [3:0] GRP_LD   = 4'h6;
    localparam logic [3:0] GRP_ADD  = 4'h7;
    localparam logic [3:0] GRP_ALU  = 4'h8;
    localparam logic [3:0] GRP_SNEV = 4'h9;
    localparam logic [3:0] GRP_LDI  = 4'hA;
    localparam logic [3:0] GRP_RND  = 4'hC;
    localparam logic [3:0] GRP_DRW  = 4'hD;
    localparam logic [3:0] GRP_MISC = 4'hF;

    // sprite engine request
    typedef struct packed {
        logic              start;
        logic [7:0]        ox;
        logic [7:0]        oy;
        logic [3:0]        rows;
        logic [ADDR_W-1:0] base;
    } draw_req_t;

endpackage

>>> rtl/core/c8core_fb.sv
// ----------------------------------------------------------------------------
// c8core_fb
// frame buffer with a row sequencer for sprite xor and clear sweeps
// ----------------------------------------------------------------------------
module c8core_fb
(
    input  logic                              clk,
    input  logic                              rst_n,
    input  c8core_pkg::draw_req_t             req,
    input  logic                              clear_start,
    output logic                              mem_rd,
    output logic [c8core_pkg::ADDR_W-1:0]     mem_addr,
    input  logic [7:0]                        mem_q,
    input  logic [c8core_pkg::ROW_W-1:0]      pix_row,
    input  logic [c8core_pkg::COL_W-1:0]      pix_col,
    output logic                              pix_value,
    output logic                              busy,
    output logic                              hit
);
    import c8core_pkg::*;

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_FETCH = 2'd1;
    localparam logic [1:0] S_XOR   = 2'd2;
    localparam logic [1:0] S_CLEAR = 2'd3;

    logic [63:0]       fb_reg [32];
    logic [1:0]        state_reg, state_next;
    logic [3:0]        row_reg;
    logic [ROW_W-1:0]  clr_reg;
    logic [7:0]        ox_reg, oy_reg;
    logic [3:0]        rows_reg;
    logic [ADDR_W-1:0] base_reg;
    logic              hit_reg;
    logic [8:0]        sy;
    logic [63:0]       mask;
    logic [71:0]       wide;

    assign sy   = {1'b0, oy_reg} + {5'd0, row_reg};
    assign wide = {64'd0, mem_q[0], mem_q[1], mem_q[2], mem_q[3],
                   mem_q[4], mem_q[5], mem_q[6], mem_q[7]} << ox_reg;
    assign mask = wide[63:0];

    assign mem_rd    = (state_reg == S_FETCH);
    assign mem_addr  = base_reg + {8'd0, row_reg};
    assign busy      = (state_reg != S_IDLE);
    assign hit       = hit_reg;
    assign pix_value = fb_reg[pix_row][pix_col];

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (clear_start)
                    state_next = S_CLEAR;
                else if (req.start && req.rows != 4'd0)
                    state_next = S_FETCH;
            end
            S_FETCH: state_next = S_XOR;
            S_XOR:   state_next = (row_reg + 4'd1 == rows_reg) ? S_IDLE : S_FETCH;
            S_CLEAR: state_next = (clr_reg == 5'd31) ? S_IDLE : S_CLEAR;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_CLEAR;
            row_reg   <= '0;
            clr_reg   <= '0;
            hit_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (state_reg == S_IDLE && req.start)
            begin
                row_reg <= '0;
                hit_reg <= 1'b0;
            end
            if (state_reg == S_IDLE && clear_start)
                clr_reg <= '0;
            if (state_reg == S_CLEAR)
                clr_reg <= clr_reg + 5'd1;
            if (state_reg == S_XOR)
            begin
                row_reg <= row_reg + 4'd1;
                if (sy < 9'd32 && (fb_reg[sy[ROW_W-1:0]] & mask) != 64'd0)
                    hit_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && req.start)
        begin
            ox_reg   <= req.ox;
            oy_reg   <= req.oy;
            rows_reg <= req.rows;
            base_reg <= req.base;
        end
        if (state_reg == S_XOR && sy < 9'd32)
            fb_reg[sy[ROW_W-1:0]] <= fb_reg[sy[ROW_W-1:0]] ^ mask;
        if (state_reg == S_CLEAR)
            fb_reg[clr_reg] <= 64'd0;
    end

endmodule

>>> rtl/core/chip8_instruction_core.sv
// ----------------------------------------------------------------------------
// chip8_instruction_core
// subset chip-8 interpreter core driven one transaction at a time
// ----------------------------------------------------------------------------
// usage: pulse start with kind and payload while busy is low. kind 0 writes a
// memory byte, 1 executes the instruction at pc, 2 reads a display pixel,
// 3 reads a V register. every transaction returns exactly one result marked
// by done for one cycle: program_counter, halted and read_value.
// from the accepting edge to the result: writes and reads go straight to the
// response state; execute walks two opcode byte fetches through the single
// memory read port, decode, execute, wait and response, and skips execute and
// wait when the core is already halted; DXYN stays in wait while the frame
// buffer sequencer fetches and xors each sprite row; 00E0 waits for a clear
// sweep over every frame buffer row. busy drops as done rises, so a new
// transaction can be taken in the cycle that carries the result.
// reset: a clearing pass walks memory one byte per cycle and the frame buffer
// one row per cycle; busy stays high until it finishes. the user must write
// program_length through cfg_we/cfg_data only while idle; the core does not
// enforce it. the receiver cannot stall: done is a single-cycle strobe.
// ----------------------------------------------------------------------------
module chip8_instruction_core
#(
    parameter int STACK_DEPTH = c8core_pkg::STACK_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [11:0] cfg_data,
    input  logic        start,
    output logic        busy,
    input  logic [1:0]  kind,
    input  logic [11:0] mem_address,
    input  logic [7:0]  mem_data,
    input  logic [7:0]  random_byte,
    input  logic [5:0]  pixel_x,
    input  logic [4:0]  pixel_y,
    input  logic [3:0]  reg_index,
    output logic        done,
    output logic [11:0] program_counter,
    output logic        halted,
    output logic [7:0]  read_value
);
    import c8core_pkg::*;

    localparam int SP_W = $clog2(STACK_DEPTH);

    localparam logic [3:0] S_WIPE  = 4'd0;
    localparam logic [3:0] S_IDLE  = 4'd1;
    localparam logic [3:0] S_FH    = 4'd2;
    localparam logic [3:0] S_FL    = 4'd3;
    localparam logic [3:0] S_DEC   = 4'd4;
    localparam logic [3:0] S_EXEC  = 4'd5;
    localparam logic [3:0] S_WAIT  = 4'd6;
    localparam logic [3:0] S_RESP  = 4'd7;
    localparam logic [3:0] S_FLUSH = 4'd8;

    logic [3:0]        state_reg, state_next;
    logic [ADDR_W:0]   wipe_reg;
    logic [7:0]        mem [4096];
    logic [7:0]        mem_q;
    logic [ADDR_W-1:0] rd_addr;
    logic              rd_en;

    logic [7:0]        v_reg [16];
    logic [ADDR_W-1:0] stack_reg [STACK_DEPTH];
    logic [SP_W-1:0]   sp_reg;
    logic [ADDR_W-1:0] i_reg, pc_reg, lj_pc_reg;
    logic              lj_valid_reg, halt_reg;
    logic [7:0]        dt_reg, st_reg;
    logic [ADDR_W-1:0] plen_reg;

    logic [1:0]        kind_reg;
    logic [7:0]        rnd_reg, rv_reg;
    logic [15:0]       op_reg;
    logic [ROW_W-1:0]  py_reg;
    logic [COL_W-1:0]  px_reg;
    logic [3:0]        ri_reg;
    logic              draw_reg;

    draw_req_t         dreq;
    logic              clr_go, fb_rd, fb_busy, fb_hit, pix;
    logic [ADDR_W-1:0] fb_addr;

    logic [3:0]        top, xi, yi;
    logic [7:0]        nn, vx;
    logic [ADDR_W-1:0] nnn, pc2, pc4;
    logic [ADDR_W:0]   limit;
    logic              stop;

    assign top = op_reg[15:12];
    assign xi  = op_reg[11:8];
    assign yi  = op_reg[7:4];
    assign nn  = op_reg[7:0];
    assign nnn = op_reg[11:0];
    assign vx  = v_reg[xi];
    assign pc2 = pc_reg + 12'd2;
    assign pc4 = pc_reg + 12'd4;
    // halt by length follows the current program_length
    assign limit = {1'b0, PROG_BASE} + {1'b0, plen_reg};
    assign stop  = halt_reg || ({1'b0, pc_reg} >= limit);

    // memory port: wipe, host write or one read per cycle
    assign rd_en   = (state_reg == S_FH) || (state_reg == S_FL) || fb_rd;
    assign rd_addr = fb_rd ? fb_addr : ((state_reg == S_FH) ? pc_reg : pc_reg + 12'd1);

    always_ff @(posedge clk)
    begin
        if (state_reg == S_WIPE)
            mem[wipe_reg[ADDR_W-1:0]] <= 8'd0;
        else if (state_reg == S_IDLE && start && kind == KIND_WRITE)
            mem[mem_address] <= mem_data;
        if (rd_en)
            mem_q <= mem[rd_addr];
    end

    assign dreq.start = (state_reg == S_EXEC) && (top == 4'hD);
    assign dreq.ox    = vx;
    assign dreq.oy    = v_reg[yi];
    assign dreq.rows  = op_reg[3:0];
    assign dreq.base  = i_reg;
    assign clr_go     = (state_reg == S_EXEC) && (op_reg == OP_CLS);

    c8core_fb u_fb
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (dreq),
        .clear_start (clr_go),
        .mem_rd      (fb_rd),
        .mem_addr    (fb_addr),
        .mem_q       (mem_q),
        .pix_row     (py_reg),
        .pix_col     (px_reg),
        .pix_value   (pix),
        .busy        (fb_busy),
        .hit         (fb_hit)
    );

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_WIPE:  state_next = (wipe_reg == 13'd4095) ? S_FLUSH : S_WIPE;
            S_FLUSH: state_next = fb_busy ? S_FLUSH : S_IDLE;
            S_IDLE:
            begin
                if (start)
                    state_next = (kind == KIND_EXEC) ? S_FH : S_RESP;
            end
            S_FH:    state_next = S_FL;
            S_FL:    state_next = S_DEC;
            S_DEC:   state_next = stop ? S_RESP : S_EXEC;
            S_EXEC:  state_next = S_WAIT;
            S_WAIT:  state_next = fb_busy ? S_WAIT : S_RESP;
            S_RESP:  state_next = S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_WIPE;
            wipe_reg     <= '0;
            sp_reg       <= '0;
            i_reg        <= '0;
            pc_reg       <= PROG_BASE;
            lj_pc_reg    <= '0;
            lj_valid_reg <= 1'b0;
            halt_reg     <= 1'b0;
            dt_reg       <= '0;
            st_reg       <= '0;
            plen_reg     <= '0;
            draw_reg     <= 1'b0;
            done         <= 1'b0;
            for (int i = 0; i < 16; i++)
                v_reg[i] <= '0;
            for (int i = 0; i < STACK_DEPTH; i++)
                stack_reg[i] <= '0;
        end
        else
        begin
            state_reg <= state_next;
            done      <= (state_reg == S_RESP);
            if (cfg_we)
                plen_reg <= cfg_data;
            if (state_reg == S_WIPE)
                wipe_reg <= wipe_reg + 13'd1;
            if (state_reg == S_DEC)
                draw_reg <= 1'b0;
            if (state_reg == S_FL)
                op_reg[15:8] <= mem_q;
            if (state_reg == S_DEC)
                op_reg[7:0] <= mem_q;
            if (state_reg == S_WAIT && !fb_busy && draw_reg)
                v_reg[15] <= {7'd0, fb_hit};
            if (state_reg == S_EXEC)
            begin
                pc_reg <= pc2;
                if (op_reg == OP_CLS)
                    pc_reg <= pc2;
                else if (top == 4'h1)
                begin
                    if (lj_valid_reg && lj_pc_reg == pc_reg)
                    begin
                        halt_reg <= 1'b1;
                        pc_reg   <= pc_reg;
                    end
                    else
                    begin
                        lj_pc_reg    <= pc_reg;
                        lj_valid_reg <= 1'b1;
                        pc_reg       <= nnn;
                    end
                end
                else if (top == 4'h6)
                    v_reg[xi] <= nn;
                else if (top == 4'h7)
                    v_reg[xi] <= vx + nn;
                else if (top == 4'hA)
                    i_reg <= nnn;
                else if (top == 4'hD)
                begin
                    v_reg[15] <= 8'd0;
                    draw_reg  <= 1'b1;
                end
                else if (top == 4'h3)
                    pc_reg <= (vx == nn) ? pc4 : pc2;
                else if (top == 4'h4)
                    pc_reg <= (vx != nn) ? pc4 : pc2;
                else if (top == 4'h8 && op_reg[3:0] == 4'd0)
                    v_reg[xi] <= v_reg[yi];
                else if (top == 4'hC)
                    v_reg[xi] <= rnd_reg & nn;
                else if (top == 4'h2)
                begin
                    stack_reg[sp_reg] <= pc2;
                    sp_reg <= (32'(sp_reg) + 1 >= STACK_DEPTH) ? '0 : sp_reg + 1'b1;
                    pc_reg <= nnn;
                end
                else if (op_reg == OP_RET)
                begin
                    sp_reg <= (sp_reg == '0) ? SP_W'(STACK_DEPTH - 1) : sp_reg - 1'b1;
                    pc_reg <= stack_reg[(sp_reg == '0) ? SP_W'(STACK_DEPTH - 1)
                                                       : sp_reg - 1'b1];
                end
                else if (top == 4'hF && nn == NN_LD_DT)
                    v_reg[xi] <= dt_reg;
                else if (top == 4'hF && nn == NN_ST_DT)
                    dt_reg <= vx;
                else if (top == 4'hF && nn == NN_ST_ST)
                    st_reg <= vx;
            end
        end
    end

    // captured transaction payload, and the result registers loaded in the response state
    always_ff @(posedge clk)
    begin
        if (state_reg == S_IDLE && start)
        begin
            kind_reg <= kind;
            rnd_reg  <= random_byte;
            px_reg   <= pixel_x;
            py_reg   <= pixel_y;
            ri_reg   <= reg_index;
        end
        if (state_reg == S_RESP)
        begin
            case (kind_reg)
                KIND_PIXEL: rv_reg <= {7'd0, pix};
                KIND_REG:   rv_reg <= v_reg[ri_reg];
                default:    rv_reg <= 8'd0;
            endcase
            program_counter <= pc_reg;
            halted          <= stop;
        end
    end

    assign read_value = rv_reg;
    assign busy = (state_reg != S_IDLE);

endmodule

>>> sim/c8core_checker.sv
// ----------------------------------------------------------------------------
// c8core_checker
// watches the chip-8 core, predicts each result and compares it
// ----------------------------------------------------------------------------
// every accepted transaction is run through a private copy of the core state
// and its expected result is queued; each done strobe is checked against
// the oldest queued result, field by field
// ----------------------------------------------------------------------------
module c8core_checker
    import c8core_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [11:0] cfg_data,
    input  logic        start,
    input  logic        busy,
    input  logic [1:0]  kind,
    input  logic [11:0] mem_address,
    input  logic [7:0]  mem_data,
    input  logic [7:0]  random_byte,
    input  logic [5:0]  pixel_x,
    input  logic [4:0]  pixel_y,
    input  logic [3:0]  reg_index,
    input  logic        done,
    input  logic [11:0] program_counter,
    input  logic        halted,
    input  logic [7:0]  read_value,
    output int          mismatches,
    output int          outstanding
);

    typedef struct packed {
        logic [11:0] pc;
        logic        halted;
        logic [7:0]  value;
    } core_result_t;

    core_result_t      expected_results[$];

    logic [7:0]        memory    [MEMORY_BYTES_DEF];
    logic [7:0]        vreg      [16];
    logic [63:0]       screen    [SCREEN_HEIGHT_DEF];
    logic [11:0]       call_stack[STACK_DEPTH_DEF];
    logic [3:0]        sp;
    logic [11:0]       index_reg;
    logic [7:0]        delay_timer;
    logic [7:0]        sound_timer;
    logic [11:0]       pc;
    logic [11:0]       jump_origin;
    logic              jump_seen;
    logic              stuck;
    logic [11:0]       prog_len;

    function automatic logic is_stopped();
        return stuck || ({1'b0, pc} >= {1'b0, PROG_BASE} + {1'b0, prog_len});
    endfunction

    task automatic clear_model();
        for (int i = 0; i < MEMORY_BYTES_DEF; i++) memory[i] = '0;
        for (int i = 0; i < 16; i++) vreg[i] = '0;
        for (int i = 0; i < SCREEN_HEIGHT_DEF; i++) screen[i] = '0;
        for (int i = 0; i < STACK_DEPTH_DEF; i++) call_stack[i] = '0;
        sp = '0;
        index_reg = '0;
        delay_timer = '0;
        sound_timer = '0;
        pc = PROG_BASE;
        jump_origin = '0;
        jump_seen = 1'b0;
        stuck = 1'b0;
        prog_len = '0;
    endtask

    // xor sprite, clipped at the right and bottom edges
    task automatic draw_sprite(input logic [3:0] x, input logic [3:0] y, input logic [3:0] n);
        int          ox;
        int          oy;
        int          sy;
        int          sx;
        logic [7:0]  bits;
        logic [11:0] a;
        logic        hit;
        ox = vreg[x];
        oy = vreg[y];
        hit = 1'b0;
        vreg[15] = '0;
        for (int r = 0; r < n; r++)
        begin
            a = index_reg + 12'(r);
            bits = memory[a];
            sy = oy + r;
            if (sy >= SCREEN_HEIGHT_DEF) continue;
            for (int c = 0; c < 8; c++)
            begin
                sx = ox + c;
                if (!bits[7-c] || sx >= SCREEN_WIDTH_DEF) continue;
                if (screen[sy][sx]) hit = 1'b1;
                screen[sy][sx] = ~screen[sy][sx];
            end
        end
        vreg[15] = {7'd0, hit};
    endtask

    task automatic run_instruction(input logic [7:0] rnd);
        logic [15:0] op;
        logic [11:0] next;
        logic [3:0]  x;
        logic [3:0]  y;
        logic [7:0]  nn;
        op = {memory[pc], memory[pc + 12'd1]};
        next = pc + 12'd2;
        x = op[11:8];
        y = op[7:4];
        nn = op[7:0];
        if (op == OP_CLS)
        begin
            for (int i = 0; i < SCREEN_HEIGHT_DEF; i++) screen[i] = '0;
            pc = next;
        end
        else if (op == OP_RET)
        begin
            sp = sp - 4'd1;
            pc = call_stack[sp];
        end
        else
        begin
            case (op[15:12])
                GRP_JP:
                begin
                    if (jump_seen && jump_origin == pc)
                        stuck = 1'b1;
                    else
                    begin
                        jump_origin = pc;
                        jump_seen = 1'b1;
                        pc = op[11:0];
                    end
                end
                GRP_CALL:
                begin
                    call_stack[sp] = next;
                    sp = sp + 4'd1;
                    pc = op[11:0];
                end
                GRP_SE:   pc = (vreg[x] == nn) ? pc + 12'd4 : next;
                GRP_SNE:  pc = (vreg[x] != nn) ? pc + 12'd4 : next;
                GRP_LD:   begin vreg[x] = nn; pc = next; end
                GRP_ADD:  begin vreg[x] = vreg[x] + nn; pc = next; end
                GRP_ALU:
                begin
                    if (op[3:0] == 4'd0) vreg[x] = vreg[y];
                    pc = next;
                end
                GRP_LDI:  begin index_reg = op[11:0]; pc = next; end
                GRP_RND:  begin vreg[x] = rnd & nn; pc = next; end
                GRP_DRW:  begin draw_sprite(x, y, op[3:0]); pc = next; end
                GRP_MISC:
                begin
                    if (nn == NN_LD_DT) vreg[x] = delay_timer;
                    else if (nn == NN_ST_DT) delay_timer = vreg[x];
                    else if (nn == NN_ST_ST) sound_timer = vreg[x];
                    pc = next;
                end
                default:  pc = next;
            endcase
        end
    endtask

    task automatic predict_transaction();
        core_result_t r;
        r.value = '0;
        case (kind)
            KIND_WRITE: memory[mem_address] = mem_data;
            KIND_EXEC:  if (!is_stopped()) run_instruction(random_byte);
            KIND_PIXEL: r.value = {7'd0, screen[pixel_y][pixel_x]};
            default:    r.value = vreg[reg_index];
        endcase
        r.pc = pc;
        r.halted = is_stopped();
        expected_results.push_back(r);
    endtask

    task automatic check_result();
        core_result_t e;
        if (expected_results.size() == 0)
        begin
            $error("result with no transaction pending: pc %0h", program_counter);
            mismatches++;
            return;
        end
        e = expected_results.pop_front();
        if (program_counter !== e.pc)
        begin
            $error("program_counter expected %0h got %0h", e.pc, program_counter);
            mismatches++;
        end
        if (halted !== e.halted)
        begin
            $error("halted expected %0b got %0b", e.halted, halted);
            mismatches++;
        end
        if (read_value !== e.value)
        begin
            $error("read_value expected %0h got %0h", e.value, read_value);
            mismatches++;
        end
    endtask

    initial
    begin
        mismatches = 0;
        outstanding = 0;
        clear_model();
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            clear_model();
        else
        begin
            if (cfg_we) prog_len = cfg_data;
            if (start && !busy) predict_transaction();
            if (done) check_result();
            outstanding = expected_results.size();
        end
    end

endmodule

>>> sim/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// random program stimulus for the chip-8 instruction core
// ----------------------------------------------------------------------------
// a directed program first covers sprite clipping and address wrap, the
// timers, call and return, clear and halt by length. then phases each load
// a short random program at the current pc, set program_length and run a
// mix of executes, reads and memory writes under varying sender idling.
// a self-jump halt closes the run. the checker does all prediction
// ----------------------------------------------------------------------------
module testbench;
    import c8core_pkg::*;

    localparam logic [11:0] MAX_LEN = 12'd3584;

    logic        clk;
    logic        rst_n;
    logic        cfg_we;
    logic [11:0] cfg_data;
    logic        start;
    logic        busy;
    logic [1:0]  kind;
    logic [11:0] mem_address;
    logic [7:0]  mem_data;
    logic [7:0]  random_byte;
    logic [5:0]  pixel_x;
    logic [4:0]  pixel_y;
    logic [3:0]  reg_index;
    logic        done;
    logic [11:0] program_counter;
    logic        halted;
    logic [7:0]  read_value;

    int          mismatches;
    int          outstanding;
    int          items_sent;
    int          results_seen = 0;
    int          idle_pct;
    logic [11:0] last_pc = PROG_BASE;

    chip8_instruction_core DUT (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .start(start), .busy(busy), .kind(kind), .mem_address(mem_address),
        .mem_data(mem_data), .random_byte(random_byte), .pixel_x(pixel_x),
        .pixel_y(pixel_y), .reg_index(reg_index), .done(done),
        .program_counter(program_counter), .halted(halted), .read_value(read_value)
    );

    c8core_checker u_checker (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .start(start), .busy(busy), .kind(kind), .mem_address(mem_address),
        .mem_data(mem_data), .random_byte(random_byte), .pixel_x(pixel_x),
        .pixel_y(pixel_y), .reg_index(reg_index), .done(done),
        .program_counter(program_counter), .halted(halted), .read_value(read_value),
        .mismatches(mismatches), .outstanding(outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // count results and keep the pc of the latest one for program placement
    always @(posedge clk)
    begin
        if (done)
        begin
            results_seen <= results_seen + 1;
            last_pc <= program_counter;
        end
    end

    // one transaction: optional idle gap, wait for busy low, then one start pulse
    task automatic send_item(input logic [1:0] k, input logic [11:0] a, input logic [7:0] d,
                             input logic [7:0] rnd, input logic [5:0] px,
                             input logic [4:0] py, input logic [3:0] ri);
        if (idle_pct != 0 && $urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            repeat ($urandom_range(1, 4)) @(negedge clk);
        end
        while (busy) @(negedge clk);
        start <= 1'b1;
        kind <= k;
        mem_address <= a;
        mem_data <= d;
        random_byte <= rnd;
        pixel_x <= px;
        pixel_y <= py;
        reg_index <= ri;
        @(negedge clk);
        start <= 1'b0;
        items_sent++;
    endtask

    task automatic write_byte(input logic [11:0] a, input logic [7:0] d);
        send_item(KIND_WRITE, a, d, 8'($urandom), 6'($urandom), 5'($urandom), 4'($urandom));
    endtask

    task automatic write_word(input logic [11:0] a, input logic [15:0] w);
        write_byte(a, w[15:8]);
        write_byte(a + 12'd1, w[7:0]);
    endtask

    task automatic exec_item();
        send_item(KIND_EXEC, 12'($urandom), 8'($urandom), 8'($urandom), 6'($urandom),
                  5'($urandom), 4'($urandom));
    endtask

    task automatic read_pixel(input logic [5:0] px, input logic [4:0] py);
        send_item(KIND_PIXEL, 12'($urandom), 8'($urandom), 8'($urandom), px, py,
                  4'($urandom));
    endtask

    task automatic read_vreg(input logic [3:0] ri);
        send_item(KIND_REG, 12'($urandom), 8'($urandom), 8'($urandom), 6'($urandom),
                  5'($urandom), ri);
    endtask

    // stop sending until every transaction has its result and the core is idle
    task automatic drain();
        start <= 1'b0;
        @(negedge clk);
        while (results_seen != items_sent || busy) @(negedge clk);
    endtask

    task automatic set_length(input logic [11:0] len);
        cfg_we <= 1'b1;
        cfg_data <= len;
        @(negedge clk);
        cfg_we <= 1'b0;
        @(negedge clk);
    endtask

    // random opcode; jumps and calls only go forward so a loop cannot halt the core
    function automatic logic [15:0] pick_opcode(input logic [11:0] at);
        logic [11:0] fwd;
        logic [15:0] op;
        logic [7:0]  nn;
        fwd = at + 12'(2 * $urandom_range(1, 4));
        nn = $urandom_range(1) ? 8'($urandom_range(3)) : 8'($urandom);
        case ($urandom_range(15))
            0:       op = OP_CLS;
            1:       op = {GRP_JP, fwd};
            2:       op = {GRP_CALL, fwd};
            3:       op = {GRP_SE, 4'($urandom), nn};
            4:       op = {GRP_SNE, 4'($urandom), nn};
            5, 6:    op = {GRP_LD, 4'($urandom), nn};
            7:       op = {GRP_ADD, 4'($urandom), 8'($urandom)};
            8:       op = {GRP_ALU, 4'($urandom), 4'($urandom), 4'd0};
            9:       op = {GRP_LDI, 12'($urandom)};
            10:      op = {GRP_RND, 4'($urandom), 8'($urandom)};
            11, 12:  op = {GRP_DRW, 4'($urandom), 4'($urandom), 4'($urandom)};
            13:
            begin
                case ($urandom_range(3))
                    0:       nn = NN_LD_DT;
                    1:       nn = NN_ST_DT;
                    2:       nn = NN_ST_ST;
                    default: nn = NN_LD_DT | 8'h10;
                endcase
                op = {GRP_MISC, 4'($urandom), nn};
            end
            14:      op = {GRP_ALU, 4'($urandom), 4'($urandom), 4'($urandom_range(1, 15))};
            default:
            begin
                // any random opcode; steer clear of backward control flow
                op = 16'($urandom);
                if (op[15:12] == GRP_JP || op[15:12] == GRP_CALL || op == OP_RET)
                    op[15:12] = GRP_SNEV;
            end
        endcase
        return op;
    endfunction

    initial
    begin
        #4000000;
        $display("tb: failure");
        $finish;
    end

    initial
    begin
        int          phase;
        int          words;
        int          burst;
        logic [11:0] base;
        logic [12:0] stop_at;
        logic [15:0] prog_words[12];

        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        start = 1'b0;
        kind = KIND_WRITE;
        mem_address = '0;
        mem_data = '0;
        random_byte = '0;
        pixel_x = '0;
        pixel_y = '0;
        reg_index = '0;
        items_sent = 0;
        idle_pct = 0;
        repeat (10) @(negedge clk);
        rst_n = 1'b1;

        // directed: empty program halts, pixel and register corners
        exec_item();
        read_pixel(6'd63, 5'd31);
        read_vreg(4'd15);
        write_byte(12'hFFF, 8'hFF);
        write_byte(12'h000, 8'h81);

        // sprite at (60,30) fetched across the top of memory, drawn twice,
        // timers, call and return, clear, jump off the end of the program
        prog_words = '{16'h603C, 16'h611E, 16'hAFFF, 16'hD012, 16'hD012, 16'hF015,
                       16'hF018, 16'hF207, 16'h2216, 16'h00E0, 16'h1218, 16'h00EE};
        for (int i = 0; i < 12; i++)
            write_word(PROG_BASE + 12'(2 * i), prog_words[i]);
        drain();
        set_length(12'h018);
        for (int i = 0; i < 5; i++) exec_item();
        read_pixel(6'd63, 5'd31);
        read_vreg(4'd15);
        for (int i = 0; i < 8; i++) exec_item();
        read_vreg(4'd2);

        // random phases, each on a fresh program at the current pc
        phase = 0;
        while (items_sent < 520)
        begin
            drain();
            case (phase % 4)
                0:       idle_pct = 0;
                1:       idle_pct = 52;
                2:       idle_pct = 16;
                default: idle_pct = 0;
            endcase
            base = last_pc;
            words = $urandom_range(3, 10);
            for (int i = 0; i < words; i++)
                write_word(base + 12'(2 * i), pick_opcode(base + 12'(2 * i)));
            // a little sprite data in low memory
            write_byte(12'($urandom_range(0, 31)), 8'($urandom));
            drain();
            stop_at = {1'b0, base} + 13'(2 * words);
            if (phase % 9 == 5)
                set_length(12'd0);
            else if (phase % 7 == 3 || stop_at < {1'b0, PROG_BASE}
                     || stop_at - {1'b0, PROG_BASE} > {1'b0, MAX_LEN})
                set_length(MAX_LEN);
            else
                set_length(12'(stop_at - {1'b0, PROG_BASE}));
            burst = words + $urandom_range(2, 8);
            for (int i = 0; i < burst; i++)
            begin
                case ($urandom_range(9))
                    0, 1:    read_pixel(6'($urandom), 5'($urandom));
                    2:       read_vreg(4'($urandom));
                    3:       write_byte($urandom_range(1) ? 12'($urandom) : 12'($urandom_range(0, 63)),
                                        8'($urandom));
                    default: exec_item();
                endcase
            end
            phase++;
        end

        // self-jump: the second jump from the same pc halts for good
        drain();
        idle_pct = 0;
        base = last_pc;
        write_word(base, {GRP_JP, base});
        drain();
        set_length(MAX_LEN);
        repeat (3) exec_item();
        read_vreg(4'd0);

        drain();
        repeat (50) @(negedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> sim.f
rtl/core/c8core_pkg.sv
rtl/core/c8core_fb.sv
rtl/core/chip8_instruction_core.sv
sim/c8core_checker.sv
sim/testbench.sv
